/* design/mff_pkg.sv */
// Shared widths, codes and controller/datapath interface types for the flooding forwarder.
package mff_pkg;

   localparam int ID_W            = 10;
   localparam int RECV_W          = 11;
   localparam int PORT_W          = 4;
   localparam int GROUP_W         = 6;
   localparam int DEF_NUM_PORTS   = 16;
   localparam int DEF_NUM_GROUPS  = 64;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [ID_W-1:0]          ROUTER_ID_RESET = 10'd1;
   localparam logic [ID_W-1:0]          CTRL_SENDER     = '0;
   localparam logic signed [RECV_W-1:0] RECV_JOIN       = -11'sd1;
   localparam logic signed [RECV_W-1:0] RECV_MCAST      = '0;

   typedef enum logic [1:0] {
      MODE_JOIN,
      MODE_MCAST,
      MODE_UNI,
      MODE_FLOOD
   } mode_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic flood_pass;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic ctrl_frame;
      logic blocked;
      logic uni_hit;
      logic at_last;
      logic is_uni;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

/* design/mff_ctrl.sv */
// Sequencing state machine of the flooding forwarder: accept, port scan, final hand-off.
module mff_ctrl import mff_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && !sts.ctrl_frame) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = !sts.blocked;
            if (cmd.step && sts.uni_hit) begin
               state_in = ST_FINISH;
            end else if (cmd.step && sts.at_last) begin
               // unicast with no host match goes round again as a router flood
               if (sts.is_uni) begin
                  cmd.flood_pass = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (!sts.pend_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

`ifndef ASSERT_OFF
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sts.pend_valid)
      else $error("pending decision left over in idle");

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && sts.blocked |=> state_ff == ST_SCAN)
      else $error("scan left while blocked on output");
`endif

endmodule

/* design/mff_dpath.sv */
// Datapath: port tables, group membership memory, scan counter, pending and output registers.
module mff_dpath import mff_pkg::*; #(
   parameter int NUM_PORTS  = DEF_NUM_PORTS,
   parameter int NUM_GROUPS = DEF_NUM_GROUPS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [ID_W-1:0]          req_sender_id,
   input  logic signed [RECV_W-1:0] req_receiver_id,
   input  logic [ID_W-1:0]          req_neighbor_id,
   input  logic [PORT_W-1:0]        req_port_index,
   input  logic                     req_neighbor_is_router,
   input  logic [GROUP_W-1:0]       req_group_number,
   input  logic                     req_has_last_hop,
   input  logic [ID_W-1:0]          req_last_hop_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PORT_W-1:0]        rsp_out_port,
   output logic [ID_W-1:0]          rsp_dest_id,
   output logic                     rsp_to_host,
   output logic                     rsp_sender_rewritten,
   output logic                     rsp_hop_appended,
   output logic                     rsp_last_of_run,
   input  logic                     csr_wr_en,
   input  logic [ID_W-1:0]          csr_wr_data
);

   localparam int PW     = $clog2(NUM_PORTS);
   // only groups reachable through the group field need storage
   localparam int NG_EFF = (NUM_GROUPS < (1 << GROUP_W)) ? NUM_GROUPS : (1 << GROUP_W);
   localparam int GW     = (NG_EFF > 1) ? $clog2(NG_EFF) : 1;

   // port tables
   logic [ID_W-1:0]      nbr_ff [NUM_PORTS];
   logic [NUM_PORTS-1:0] pvalid_ff;
   logic [NUM_PORTS-1:0] prouter_ff;
   logic [PW-1:0]        widx;
   logic                 tbl_we;

   // group membership memory, one row of port bits per group
   logic [NUM_PORTS-1:0] grp_mem [NG_EFF];
   logic [NG_EFF-1:0]    grp_valid_ff;
   logic [NUM_PORTS-1:0] row_ff;
   logic                 rowv_ff;
   logic [GW-1:0]        ridx;
   logic                 grp_we;
   logic [NUM_PORTS-1:0] join_bit;
   logic [NUM_PORTS-1:0] row_wdata;

   // latched item
   logic [ID_W-1:0]          sender_ff;
   logic signed [RECV_W-1:0] recv_ff;
   logic [GROUP_W-1:0]       grp_ff;
   logic                     hop_ff;
   logic [ID_W-1:0]          hop_id_ff;
   mode_type                 mode_ff;
   mode_type                 mode_in;
   logic                     group_ok;

   // scan
   logic [PW-1:0]        cnt_ff;
   logic [PW-1:0]        cnt_in;
   logic [RES_CNT_W-1:0] res_cnt_ff;
   logic [RES_CNT_W-1:0] res_cnt_in;
   logic                 join_found_ff;
   logic                 join_found_in;
   logic [PW-1:0]        join_port_ff;

   logic [ID_W-1:0] p_nbr;
   logic            p_valid;
   logic            p_router;
   logic            hop_block;
   logic            flood_hit;
   logic            recv_pos;
   logic            uni_match;
   logic            member;
   logic            hit;
   logic            take;
   logic            d_host;
   logic            d_rew;
   logic            d_hop;

   // pending decision, held until the next one shows whether it was the last
   logic            pend_valid_ff;
   logic            pend_valid_in;
   logic [PW-1:0]   pend_port_ff;
   logic [ID_W-1:0] pend_dest_ff;
   logic            pend_host_ff;
   logic            pend_rew_ff;
   logic            pend_hop_ff;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [PORT_W-1:0] rsp_port_ff;
   logic [ID_W-1:0] rsp_dest_ff;
   logic            rsp_host_ff;
   logic            rsp_rew_ff;
   logic            rsp_hop_ff;
   logic            rsp_last_ff;
   logic            out_free;
   logic            push_mid;
   logic            push_end;

   logic [ID_W-1:0] router_id_ff;

   assign widx   = PW'(req_port_index);
   assign tbl_we = cmd.accept && (req_sender_id == CTRL_SENDER)
                   && (32'(req_port_index) < NUM_PORTS);

   assign group_ok = (32'(grp_ff) < NUM_GROUPS);
   assign ridx     = cmd.accept ? GW'(req_group_number) : GW'(grp_ff);

   always_comb begin
      join_bit               = '0;
      join_bit[join_port_ff] = 1'b1;
   end
   assign row_wdata = (rowv_ff ? row_ff : '0) | join_bit;
   assign grp_we    = cmd.finish && (mode_ff == MODE_JOIN) && join_found_ff && group_ok;

   always_comb begin
      p_nbr     = nbr_ff[cnt_ff];
      p_valid   = pvalid_ff[cnt_ff];
      p_router  = prouter_ff[cnt_ff];
      hop_block = hop_ff && (p_nbr == hop_id_ff);
      flood_hit = p_valid && p_router && !hop_block;
      recv_pos  = !recv_ff[RECV_W-1] && (recv_ff != RECV_MCAST);
      uni_match = p_valid && !p_router && recv_pos && (p_nbr == recv_ff[ID_W-1:0]);
      member    = group_ok && rowv_ff && row_ff[cnt_ff] && p_valid;
      case (mode_ff)
         MODE_JOIN: begin
            hit = flood_hit;  d_host = 1'b0;      d_rew = 1'b1; d_hop = 1'b1;
         end
         MODE_MCAST: begin
            hit = member && (!p_router || !hop_block);
            d_host = !p_router; d_rew = 1'b0; d_hop = 1'b1;
         end
         MODE_UNI: begin
            hit = uni_match;  d_host = 1'b1;      d_rew = 1'b0; d_hop = 1'b0;
         end
         MODE_FLOOD: begin
            hit = flood_hit;  d_host = 1'b0;      d_rew = 1'b0; d_hop = 1'b1;
         end
         default: begin
            hit = 1'b0;       d_host = 1'b0;      d_rew = 1'b0; d_hop = 1'b0;
         end
      endcase
   end

   assign take     = hit && (res_cnt_ff < RES_CNT_W'(MAX_RESULTS));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push_mid = cmd.step && take && pend_valid_ff;
   assign push_end = cmd.finish && pend_valid_ff && out_free;

   always_comb begin
      sts            = '0;
      sts.ctrl_frame = (req_sender_id == CTRL_SENDER);
      sts.blocked    = take && pend_valid_ff && !out_free;
      sts.uni_hit    = take && (mode_ff == MODE_UNI);
      sts.at_last    = (cnt_ff == PW'(NUM_PORTS - 1));
      sts.is_uni     = (mode_ff == MODE_UNI);
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   always_comb begin
      cnt_in        = cnt_ff;
      mode_in       = mode_ff;
      res_cnt_in    = res_cnt_ff;
      join_found_in = join_found_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.accept) begin
         cnt_in        = '0;
         res_cnt_in    = '0;
         join_found_in = 1'b0;
         pend_valid_in = 1'b0;
         if (req_receiver_id == RECV_JOIN) begin
            mode_in = MODE_JOIN;
         end else if (req_receiver_id == RECV_MCAST) begin
            mode_in = MODE_MCAST;
         end else begin
            mode_in = MODE_UNI;
         end
      end else begin
         if (cmd.step) begin
            cnt_in = cnt_ff + 1'b1;
            if (take) begin
               pend_valid_in = 1'b1;
               res_cnt_in    = res_cnt_ff + 1'b1;
            end
            if ((mode_ff == MODE_JOIN) && !join_found_ff && p_valid
                && (p_nbr == sender_ff)) begin
               join_found_in = 1'b1;
            end
         end
         if (cmd.flood_pass) begin
            cnt_in  = '0;
            mode_in = MODE_FLOOD;
         end
         if (push_end) begin
            pend_valid_in = 1'b0;
         end
      end
      if (push_mid || push_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         mode_ff       <= MODE_UNI;
         res_cnt_ff    <= '0;
         join_found_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pvalid_ff     <= '0;
         prouter_ff    <= '0;
         grp_valid_ff  <= '0;
         router_id_ff  <= ROUTER_ID_RESET;
      end else begin
         cnt_ff        <= cnt_in;
         mode_ff       <= mode_in;
         res_cnt_ff    <= res_cnt_in;
         join_found_ff <= join_found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (tbl_we) begin
            pvalid_ff[widx] <= 1'b1;
            if (req_neighbor_is_router) begin
               prouter_ff[widx] <= 1'b1;   // router flag is sticky
            end
         end
         if (grp_we) begin
            grp_valid_ff[GW'(grp_ff)] <= 1'b1;
         end
         if (csr_wr_en) begin
            router_id_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         nbr_ff[widx] <= req_neighbor_id;
      end
      if (cmd.accept) begin
         sender_ff <= req_sender_id;
         recv_ff   <= req_receiver_id;
         grp_ff    <= req_group_number;
         hop_ff    <= req_has_last_hop;
         hop_id_ff <= req_last_hop_id;
      end
      if (cmd.step && (mode_ff == MODE_JOIN) && !join_found_ff && p_valid
          && (p_nbr == sender_ff)) begin
         join_port_ff <= cnt_ff;
      end
      if (cmd.step && take) begin
         pend_port_ff <= cnt_ff;
         pend_dest_ff <= p_nbr;
         pend_host_ff <= d_host;
         pend_rew_ff  <= d_rew;
         pend_hop_ff  <= d_hop;
      end
      if (push_mid || push_end) begin
         rsp_port_ff <= PORT_W'(pend_port_ff);
         rsp_dest_ff <= pend_dest_ff;
         rsp_host_ff <= pend_host_ff;
         rsp_rew_ff  <= pend_rew_ff;
         rsp_hop_ff  <= pend_hop_ff;
         rsp_last_ff <= push_end;
      end
   end

   // membership memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[GW'(grp_ff)] <= row_wdata;
      end
      row_ff  <= grp_mem[ridx];
      rowv_ff <= grp_valid_ff[ridx];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_port         = rsp_port_ff;
   assign rsp_dest_id          = rsp_dest_ff;
   assign rsp_to_host          = rsp_host_ff;
   assign rsp_sender_rewritten = rsp_rew_ff;
   assign rsp_hop_appended     = rsp_hop_ff;
   assign rsp_last_of_run      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("decision count past limit");

   a_uni_single: assert property (@(posedge clock) disable iff (reset)
      !(mode_ff == MODE_UNI && res_cnt_ff > RES_CNT_W'(1)))
      else $error("more than one unicast decision");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (push_mid || push_end) |-> out_free)
      else $error("output register overwritten while held");
`endif

endmodule

/* design/multicast_flooding_forwarder.sv */
// Flooding forwarder with multicast groups: one frame header in, zero or more
// port decisions out. A control frame (sender 0) updates the port table in its
// accept cycle and gives nothing. Any other item scans the port table one entry
// per cycle while the result side does not hold it off: a join or multicast
// scans every port once, a unicast with a host match at port i stops there, and
// a unicast with no host match scans twice (host search, then a router flood).
// The port-table scan is what sets the rate. The
// decision marked last_of_run leaves once the scan is complete; a new item is
// taken while earlier results still sit in the output register.
module multicast_flooding_forwarder import mff_pkg::*; #(
   parameter int NUM_PORTS  = DEF_NUM_PORTS,
   parameter int NUM_GROUPS = DEF_NUM_GROUPS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ID_W-1:0]          req_sender_id,
   input  logic signed [RECV_W-1:0] req_receiver_id,
   input  logic [ID_W-1:0]          req_neighbor_id,
   input  logic [PORT_W-1:0]        req_port_index,
   input  logic                     req_neighbor_is_router,
   input  logic [GROUP_W-1:0]       req_group_number,
   input  logic                     req_has_last_hop,
   input  logic [ID_W-1:0]          req_last_hop_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PORT_W-1:0]        rsp_out_port,
   output logic [ID_W-1:0]          rsp_dest_id,
   output logic                     rsp_to_host,
   output logic                     rsp_sender_rewritten,
   output logic                     rsp_hop_appended,
   output logic                     rsp_last_of_run,
   input  logic                     csr_wr_en,
   input  logic [ID_W-1:0]          csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   mff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mff_dpath #(
      .NUM_PORTS  (NUM_PORTS),
      .NUM_GROUPS (NUM_GROUPS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_sender_id          (req_sender_id),
      .req_receiver_id        (req_receiver_id),
      .req_neighbor_id        (req_neighbor_id),
      .req_port_index         (req_port_index),
      .req_neighbor_is_router (req_neighbor_is_router),
      .req_group_number       (req_group_number),
      .req_has_last_hop       (req_has_last_hop),
      .req_last_hop_id        (req_last_hop_id),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_port           (rsp_out_port),
      .rsp_dest_id            (rsp_dest_id),
      .rsp_to_host            (rsp_to_host),
      .rsp_sender_rewritten   (rsp_sender_rewritten),
      .rsp_hop_appended       (rsp_hop_appended),
      .rsp_last_of_run        (rsp_last_of_run),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

endmodule
